// ===== sv/aes128_block_cipher_top_macros.svh =====
// Assertion macros for the AES-128 block. Both expect clk and rst_n in scope.
`ifndef AES128_BLOCK_CIPHER_TOP_MACROS_SVH
`define AES128_BLOCK_CIPHER_TOP_MACROS_SVH
`ifndef SYNTH
`define AESC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define AESC_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define AESC_ASSERT(label, prop)
`define AESC_ASSERT_NEVER(label, expr)
`endif
`endif

// ===== sv/aesc_pkg.sv =====
`timescale 1ns / 1ps
package aesc_pkg;

    localparam int NumRounds = 10;

    typedef logic [127:0] block_t;
    typedef logic [NumRounds:0][127:0] rk_array_t;

    // Control that travels with each transaction through the pipeline.
    typedef struct packed {
        logic valid;
        logic func;
    } ctl_t;

    localparam logic [7:0] FwdSub [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] InvSub [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] get_byte(input block_t s, input int i);
        get_byte = s[127 - 8 * i -: 8];
    endfunction

    function automatic block_t sub_bytes(input block_t s);
        block_t o;
        for (int i = 0; i < 16; i++)
        begin
            o[127 - 8 * i -: 8] = FwdSub[get_byte(s, i)];
        end
        sub_bytes = o;
    endfunction

    function automatic block_t inv_sub_bytes(input block_t s);
        block_t o;
        for (int i = 0; i < 16; i++)
        begin
            o[127 - 8 * i -: 8] = InvSub[get_byte(s, i)];
        end
        inv_sub_bytes = o;
    endfunction

    // Row r of column c takes the byte from column c + r.
    function automatic block_t shift_rows(input block_t s);
        block_t o;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                o[127 - 8 * (c * 4 + r) -: 8] = get_byte(s, ((c + r) % 4) * 4 + r);
            end
        end
        shift_rows = o;
    endfunction

    function automatic block_t inv_shift_rows(input block_t s);
        block_t o;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                o[127 - 8 * (((c + r) % 4) * 4 + r) -: 8] = get_byte(s, c * 4 + r);
            end
        end
        inv_shift_rows = o;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t o;
        logic [7:0] a [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                a[k] = get_byte(s, c * 4 + k);
            end
            for (int r = 0; r < 4; r++)
            begin
                o[127 - 8 * (c * 4 + r) -: 8] = xt(a[r]) ^ xt(a[(r + 1) % 4])
                    ^ a[(r + 1) % 4] ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
            end
        end
        mix_columns = o;
    endfunction

    function automatic block_t inv_mix_columns(input block_t s);
        block_t o;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                a[k] = get_byte(s, c * 4 + k);
                x2[k] = xt(a[k]);
                x4[k] = xt(x2[k]);
                x8[k] = xt(x4[k]);
            end
            // Coefficients 14, 11, 13, 9 along the row.
            for (int r = 0; r < 4; r++)
            begin
                o[127 - 8 * (c * 4 + r) -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r])
                    ^ (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ a[(r + 1) % 4])
                    ^ (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ a[(r + 2) % 4])
                    ^ (x8[(r + 3) % 4] ^ a[(r + 3) % 4]);
            end
        end
        inv_mix_columns = o;
    endfunction

endpackage

// ===== sv/aesc_keyexp.sv =====
`timescale 1ns / 1ps
module aesc_keyexp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 key_load,
    input  aesc_pkg::block_t     key_in,
    output logic                 busy,
    output aesc_pkg::rk_array_t  round_keys
);
    import aesc_pkg::*;

    logic                        busy_reg;
    logic                        busy_next;
    logic [3:0]                  rnd_reg;
    logic [3:0]                  rnd_next;
    logic [7:0]                  rcon_reg;
    block_t                      last_key_reg;
    block_t                      key_step;
    logic [NumRounds:1][127:0]   rk_reg;
    logic [31:0]                 tw;

    // One key-schedule round on the most recent round key.
    always_comb
    begin
        tw = {FwdSub[last_key_reg[23:16]], FwdSub[last_key_reg[15:8]],
              FwdSub[last_key_reg[7:0]], FwdSub[last_key_reg[31:24]]}
             ^ {rcon_reg, 24'h0};
        key_step[127:96] = last_key_reg[127:96] ^ tw;
        key_step[95:64]  = last_key_reg[95:64] ^ key_step[127:96];
        key_step[63:32]  = last_key_reg[63:32] ^ key_step[95:64];
        key_step[31:0]   = last_key_reg[31:0] ^ key_step[63:32];
    end

    // Sequencer: a seed step, then one round key per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        if (key_load)
        begin
            busy_next = 1'b1;
            rnd_next  = 4'd0;
        end
        else if (busy_reg)
        begin
            rnd_next = rnd_reg + 4'd1;
            if (rnd_reg == 4'(NumRounds))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            rnd_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
        end
    end

    // Round key storage; each round key is written at its own step.
    always_ff @(posedge clk)
    begin
        if (busy_reg && !key_load)
        begin
            if (rnd_reg == 4'd0)
            begin
                last_key_reg <= key_in;
                rcon_reg     <= 8'h01;
            end
            else
            begin
                last_key_reg <= key_step;
                rcon_reg     <= xt(rcon_reg);
                for (int i = 1; i <= NumRounds; i++)
                begin
                    if (rnd_reg == 4'(i))
                    begin
                        rk_reg[i] <= key_step;
                    end
                end
            end
        end
    end

    assign busy = busy_reg;

    always_comb
    begin
        round_keys[0] = key_in;
        for (int i = 1; i <= NumRounds; i++)
        begin
            round_keys[i] = rk_reg[i];
        end
    end

endmodule

// ===== sv/aesc_round.sv =====
`timescale 1ns / 1ps
module aesc_round (
    input  logic              clk,
    input  logic              rst_n,
    input  aesc_pkg::ctl_t    ctl_in,
    input  aesc_pkg::block_t  state_in,
    input  aesc_pkg::block_t  enc_key,
    input  aesc_pkg::block_t  dec_key,
    input  logic              last,
    output aesc_pkg::ctl_t    ctl_out,
    output aesc_pkg::block_t  state_out
);
    import aesc_pkg::*;

    ctl_t    ctl_reg;
    block_t  state_reg;
    block_t  state_next;
    block_t  enc_sr;
    block_t  dec_ak;

    // Forward and inverse round side by side; the direction bit picks one.
    always_comb
    begin
        enc_sr = shift_rows(sub_bytes(state_in));
        dec_ak = inv_sub_bytes(inv_shift_rows(state_in)) ^ dec_key;
        if (ctl_in.func)
        begin
            state_next = last ? dec_ak : inv_mix_columns(dec_ak);
        end
        else
        begin
            state_next = (last ? enc_sr : mix_columns(enc_sr)) ^ enc_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign ctl_out   = ctl_reg;
    assign state_out = state_reg;

endmodule

// ===== sv/aes128_block_cipher_top.sv =====
`timescale 1ns / 1ps
// AES-128 encrypt/decrypt engine, fully pipelined.
// Key: written through the APB port as key_high (address 0) and key_low
// (address 8). Each write re-runs the key schedule with busy high; round
// keys are then held until the next key write.
// Command: a transaction is taken at a clock edge with start high and busy
// low; func selects encrypt (0) or decrypt (1), data_high/data_low hold the
// block. A new transaction may be started in every cycle.
// Result: out_high/out_low are valid for one cycle while done is high,
// after the command has passed one key-addition stage and ten round
// stages. Results leave in command order.
// Throughput: one block per cycle while busy is low (ten unrolled rounds).
// Reset: key registers clear to zero and the key schedule runs with busy
// high before the first command is taken.
// The receiver has no back pressure; done must be sampled when it comes.
module aes128_block_cipher_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         start,
    output logic         busy,
    input  logic         func,
    input  logic [63:0]  data_high,
    input  logic [63:0]  data_low,
    output logic         done,
    output logic [63:0]  out_high,
    output logic [63:0]  out_low
);
    import aesc_pkg::*;

    `include "aes128_block_cipher_top_macros.svh"

    logic                  cfg_wr;
    logic [63:0]           key_high_reg;
    logic [63:0]           key_low_reg;
    logic                  ks_busy;
    rk_array_t             round_keys;
    ctl_t                  ctl0_reg;
    block_t                state0_reg;
    ctl_t   [NumRounds:0]  ctl_pipe;
    block_t [NumRounds:0]  state_pipe;
    logic                  accept;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[3] ? key_low_reg : key_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3])
            begin
                key_low_reg <= pwdata;
            end
            else
            begin
                key_high_reg <= pwdata;
            end
        end
    end

    aesc_keyexp u_keyexp (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_load   (cfg_wr),
        .key_in     ({key_high_reg, key_low_reg}),
        .busy       (ks_busy),
        .round_keys (round_keys)
    );

    assign busy   = ks_busy;
    assign accept = start && !ks_busy;

    // Initial key addition stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else
        begin
            ctl0_reg <= '{valid: accept, func: func};
        end
    end

    always_ff @(posedge clk)
    begin
        state0_reg <= {data_high, data_low}
                      ^ (func ? round_keys[NumRounds] : round_keys[0]);
    end

    assign ctl_pipe[0]   = ctl0_reg;
    assign state_pipe[0] = state0_reg;

    // Ten round stages; stage j uses round key j forward, 10 - j inverse.
    for (genvar j = 1; j <= NumRounds; j++)
    begin : g_round
        aesc_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (ctl_pipe[j - 1]),
            .state_in  (state_pipe[j - 1]),
            .enc_key   (round_keys[j]),
            .dec_key   (round_keys[NumRounds - j]),
            .last      (j == NumRounds),
            .ctl_out   (ctl_pipe[j]),
            .state_out (state_pipe[j])
        );
    end

    assign done     = ctl_pipe[NumRounds].valid;
    assign out_high = state_pipe[NumRounds][127:64];
    assign out_low  = state_pipe[NumRounds][63:0];

    `AESC_ASSERT(a_latency, accept |-> ##11 done)
    `AESC_ASSERT(a_key_write_busy, cfg_wr |=> busy)
    `AESC_ASSERT(a_stage0_valid, ctl0_reg.valid == $past(accept))
    `AESC_ASSERT_NEVER(a_no_accept_busy, ctl0_reg.valid && $past(ks_busy))

endmodule
